@@ sv/ffa_pkg.sv @@
package ffa_pkg;

  // Build-time defaults
  localparam int MEM_UNITS_DEF    = 1024;
  localparam int MAX_REQUESTS_DEF = 1024;

  // Fixed field widths
  localparam int FIELD_W = 11;
  localparam int WORD_W  = 8;                   // cells per occupancy word

  localparam logic [FIELD_W-1:0] TOTAL_UNITS_RST = FIELD_W'(1024);

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef struct packed {
    logic               func;
    logic [FIELD_W-1:0] size;
    logic [FIELD_W-1:0] ref_request;
  } req_t;

  typedef struct packed {
    logic [FIELD_W-1:0] start_address;
    logic               failed;
  } rsp_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_MARK_RD,
    S_MARK_WR,
    S_FIN
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic clr;
    logic load;
    logic scan;
    logic mark_init;
    logic mark_rd;
    logic mark_wr;
    logic commit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic is_free;
    logic fail_fast;
    logic rec_live;
    logic scan_done;
    logic scan_hit;
    logic mark_last;
  } sts_t;

endpackage

@@ sv/ffa_ctrl.sv @@
module ffa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  ffa_pkg::sts_t sts_i,
  output ffa_pkg::cmd_t cmd_o,
  output logic          busy
);

  ffa_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ffa_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ffa_pkg::S_CLEAR: begin
        if (sts_i.clr_last) state_d = ffa_pkg::S_IDLE;
      end
      ffa_pkg::S_IDLE: begin
        if (start) state_d = ffa_pkg::S_CHECK;
      end
      ffa_pkg::S_CHECK: begin
        if (sts_i.is_free) begin
          state_d = sts_i.rec_live ? ffa_pkg::S_MARK_RD : ffa_pkg::S_FIN;
        end else begin
          state_d = sts_i.fail_fast ? ffa_pkg::S_FIN : ffa_pkg::S_SCAN;
        end
      end
      ffa_pkg::S_SCAN: begin
        if (sts_i.scan_done) begin
          state_d = sts_i.scan_hit ? ffa_pkg::S_MARK_RD : ffa_pkg::S_FIN;
        end
      end
      ffa_pkg::S_MARK_RD: state_d = ffa_pkg::S_MARK_WR;
      ffa_pkg::S_MARK_WR: begin
        if (sts_i.mark_last) state_d = ffa_pkg::S_FIN;
        else state_d = ffa_pkg::S_MARK_RD;
      end
      ffa_pkg::S_FIN: state_d = ffa_pkg::S_IDLE;
      default: state_d = ffa_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o = '0;
    busy  = 1'b1;
    case (state_q)
      ffa_pkg::S_CLEAR: cmd_o.clr = 1'b1;
      ffa_pkg::S_IDLE: begin
        busy       = 1'b0;
        cmd_o.load = start;
      end
      ffa_pkg::S_CHECK: begin
        cmd_o.mark_init = sts_i.is_free && sts_i.rec_live;
      end
      ffa_pkg::S_SCAN: begin
        cmd_o.scan      = 1'b1;
        cmd_o.mark_init = sts_i.scan_done && sts_i.scan_hit;
      end
      ffa_pkg::S_MARK_RD: cmd_o.mark_rd = 1'b1;
      ffa_pkg::S_MARK_WR: cmd_o.mark_wr = 1'b1;
      ffa_pkg::S_FIN: cmd_o.commit = 1'b1;
      default: cmd_o = '0;
    endcase
  end

endmodule

@@ sv/ffa_datapath.sv @@
module ffa_datapath #(
  parameter int MEM_UNITS    = ffa_pkg::MEM_UNITS_DEF,
  parameter int MAX_REQUESTS = ffa_pkg::MAX_REQUESTS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ffa_pkg::cmd_t                cmd_i,
  output ffa_pkg::sts_t                sts_o,
  input  ffa_pkg::req_t                req_i,
  input  logic                         cfg_we_i,
  input  logic [ffa_pkg::FIELD_W-1:0]  cfg_wdata_i,
  output ffa_pkg::rsp_t                rsp_o,
  output logic                         rsp_valid_o
);

  localparam int FW        = ffa_pkg::FIELD_W;
  localparam int WW        = ffa_pkg::WORD_W;
  localparam int CA_W      = $clog2(MEM_UNITS);
  localparam int CNT_W     = $clog2(MEM_UNITS + 1);
  localparam int NUM_WORDS = (MEM_UNITS + WW - 1) / WW;
  localparam int WA_W      = $clog2(NUM_WORDS);
  localparam int WC_W      = $clog2(NUM_WORDS + 1);
  localparam int RI_W      = $clog2(MAX_REQUESTS);
  localparam int RC_W      = $clog2(MAX_REQUESTS + 1);

  typedef struct packed {
    logic            valid;
    logic [CA_W-1:0] start;
    logic [FW-1:0]   len;
  } rec_t;

  // Memories
  logic [WW-1:0] map_mem [NUM_WORDS];
  rec_t          rec_mem [MAX_REQUESTS];

  logic [WW-1:0] map_rdata_q;
  rec_t          rec_rdata_q;

  logic            map_re, map_we;
  logic [WA_W-1:0] map_addr;
  logic [WW-1:0]   map_wdata;
  logic            rec_re, rec_we;
  logic [RI_W-1:0] rec_addr;
  rec_t            rec_wdata;

  always_ff @(posedge clk_i) begin
    if (map_we) map_mem[map_addr] <= map_wdata;
    if (map_re) map_rdata_q <= map_mem[map_addr];
  end

  always_ff @(posedge clk_i) begin
    if (rec_we) rec_mem[rec_addr] <= rec_wdata;
    if (rec_re) rec_rdata_q <= rec_mem[rec_addr];
  end

  // Control registers
  logic [FW-1:0]    total_q;
  logic [RC_W-1:0]  cnt_q;
  logic [WA_W-1:0]  clr_q;
  ffa_pkg::req_t    item_q;
  logic [RI_W-1:0]  ref_idx_q;
  logic [CNT_W-1:0] limit_q;
  logic [WC_W-1:0]  rd_word_q;
  logic [WA_W-1:0]  ev_word_q;
  logic             ev_vld_q;
  logic [CNT_W-1:0] run_len_q;
  logic [CA_W-1:0]  run_start_q;
  logic             found_q;
  logic [CA_W-1:0]  where_q;
  logic [CNT_W-1:0] lo_q, hi_q;
  logic [WA_W-1:0]  mw_q, mw_last_q;
  logic             rsp_valid_q;
  ffa_pkg::rsp_t    rsp_q;

  logic have_slot;
  assign have_slot = 32'(cnt_q) < 32'(MAX_REQUESTS);

  // Scan one word: walk its cells upward, tracking the current free run
  logic [CNT_W-1:0] ev_len;
  logic [CA_W-1:0]  ev_start;
  logic             ev_hit;
  logic [CA_W-1:0]  ev_where;
  logic             ev_end;

  always_comb begin
    logic [31:0] c;
    logic        occ;
    ev_len   = run_len_q;
    ev_start = run_start_q;
    ev_hit   = 1'b0;
    ev_where = run_start_q;
    for (int i = 0; i < WW; i++) begin
      c   = 32'(ev_word_q) * 32'(WW) + 32'(i);
      occ = map_rdata_q[i] || (c >= 32'(limit_q));
      if (!ev_hit) begin
        if (occ) begin
          ev_len = '0;
        end else begin
          if (ev_len == '0) ev_start = CA_W'(c);
          ev_len = ev_len + CNT_W'(1);
          if (32'(ev_len) >= 32'(item_q.size)) begin
            ev_hit   = 1'b1;
            ev_where = ev_start;
          end
        end
      end
    end
    ev_end = (32'(ev_word_q) + 32'd1) * 32'(WW) >= 32'(limit_q);
  end

  // Mark range for the cells to set or release
  logic [31:0] free_hi, alloc_hi, mark_lo, mark_hi;
  always_comb begin
    free_hi  = 32'(rec_rdata_q.start) + 32'(rec_rdata_q.len);
    if (free_hi > 32'(MEM_UNITS)) free_hi = 32'(MEM_UNITS);
    alloc_hi = 32'(ev_where) + 32'(item_q.size);
    if (item_q.func == ffa_pkg::FUNC_FREE) begin
      mark_lo = 32'(rec_rdata_q.start);
      mark_hi = free_hi;
    end else begin
      mark_lo = 32'(ev_where);
      mark_hi = alloc_hi;
    end
  end

  logic [WW-1:0] mark_mask;
  always_comb begin
    logic [31:0] c;
    for (int i = 0; i < WW; i++) begin
      c = 32'(mw_q) * 32'(WW) + 32'(i);
      mark_mask[i] = (c >= 32'(lo_q)) && (c < 32'(hi_q));
    end
  end

  // Memory port selection
  always_comb begin
    map_re    = 1'b0;
    map_we    = 1'b0;
    map_addr  = mw_q;
    map_wdata = '0;
    if (cmd_i.clr) begin
      map_we   = 1'b1;
      map_addr = clr_q;
    end else if (cmd_i.scan) begin
      map_re   = 32'(rd_word_q) < 32'(NUM_WORDS);
      map_addr = rd_word_q[WA_W-1:0];
    end else if (cmd_i.mark_rd) begin
      map_re = 1'b1;
    end else if (cmd_i.mark_wr) begin
      map_we    = 1'b1;
      map_wdata = (item_q.func == ffa_pkg::FUNC_FREE) ? (map_rdata_q & ~mark_mask)
                                                      : (map_rdata_q | mark_mask);
    end
  end

  always_comb begin
    rec_re    = 1'b0;
    rec_we    = 1'b0;
    rec_addr  = ref_idx_q;
    rec_wdata = '0;
    if (cmd_i.load) begin
      rec_re   = 1'b1;
      rec_addr = RI_W'(32'(req_i.ref_request) - 32'd1);
    end else if (cmd_i.mark_init && item_q.func == ffa_pkg::FUNC_FREE) begin
      rec_we = 1'b1;
    end else if (cmd_i.commit) begin
      rec_we          = have_slot;
      rec_addr        = cnt_q[RI_W-1:0];
      rec_wdata.valid = (item_q.func == ffa_pkg::FUNC_ALLOC) && found_q;
      rec_wdata.start = where_q;
      rec_wdata.len   = item_q.size;
    end
  end

  // Status
  always_comb begin
    sts_o           = '0;
    sts_o.clr_last  = 32'(clr_q) == 32'(NUM_WORDS - 1);
    sts_o.is_free   = item_q.func == ffa_pkg::FUNC_FREE;
    sts_o.fail_fast = (item_q.size == '0) || !have_slot || (limit_q == '0);
    sts_o.rec_live  = rec_rdata_q.valid && (item_q.ref_request != '0)
                      && (32'(item_q.ref_request) <= 32'(MAX_REQUESTS))
                      && (32'(item_q.ref_request) <= 32'(cnt_q));
    sts_o.scan_done = ev_vld_q && (ev_hit || ev_end);
    sts_o.scan_hit  = ev_vld_q && ev_hit;
    sts_o.mark_last = mw_q == mw_last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= ffa_pkg::TOTAL_UNITS_RST;
      cnt_q       <= '0;
      clr_q       <= '0;
      ev_vld_q    <= 1'b0;
      rsp_valid_q <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      rsp_valid_q <= 1'b0;
      if (cfg_we_i) total_q <= cfg_wdata_i;
      if (cmd_i.clr) clr_q <= clr_q + WA_W'(1);
      if (cmd_i.load) begin
        found_q  <= 1'b0;
        ev_vld_q <= 1'b0;
      end
      if (cmd_i.scan) begin
        ev_vld_q <= map_re;
        if (sts_o.scan_hit) found_q <= 1'b1;
      end
      if (cmd_i.commit) begin
        if (have_slot) cnt_q <= cnt_q + RC_W'(1);
        rsp_valid_q <= item_q.func == ffa_pkg::FUNC_ALLOC;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q      <= req_i;
      ref_idx_q   <= RI_W'(32'(req_i.ref_request) - 32'd1);
      limit_q     <= (32'(total_q) < 32'(MEM_UNITS)) ? CNT_W'(total_q) : CNT_W'(MEM_UNITS);
      rd_word_q   <= '0;
      ev_word_q   <= '0;
      run_len_q   <= '0;
      run_start_q <= '0;
    end
    if (cmd_i.scan) begin
      if (map_re) rd_word_q <= rd_word_q + WC_W'(1);
      ev_word_q <= rd_word_q[WA_W-1:0];
      if (ev_vld_q) begin
        run_len_q   <= ev_len;
        run_start_q <= ev_start;
        if (ev_hit) where_q <= ev_where;
      end
    end
    if (cmd_i.mark_init) begin
      lo_q      <= CNT_W'(mark_lo);
      hi_q      <= CNT_W'(mark_hi);
      mw_q      <= WA_W'(mark_lo / 32'(WW));
      mw_last_q <= WA_W'((mark_hi - 32'd1) / 32'(WW));
    end
    if (cmd_i.mark_wr) mw_q <= mw_q + WA_W'(1);
    if (cmd_i.commit) begin
      rsp_q.failed        <= !found_q;
      rsp_q.start_address <= found_q ? FW'(32'(where_q) + 32'd1) : '0;
    end
  end

  assign rsp_o       = rsp_q;
  assign rsp_valid_o = rsp_valid_q;

endmodule

@@ sv/first_fit_allocator_unit.sv @@
// First-fit allocator over a linear memory of cells. Raise start with a request
// word on req_i while busy is low; it is taken at that clock edge. An allocate
// answers with exactly one word on rsp_o, flagged by rsp_valid_o for a single
// cycle; the receiver cannot stall it, so capture it then. A free gives no word.
// After reset the occupancy map is swept clear, one 8-cell word a cycle, with
// busy high; configuration writes are taken throughout. An allocate keeps busy
// high while it scans up to min(total_units, MEM_UNITS) cells of the
// single-port occupancy memory (stopping early when a run is found), and while
// it marks each map word of the grant with a read and then a write. An allocate
// refused outright (zero size, a total_units of zero, request numbers used up)
// skips the scan. A free releases each map word of its grant with a read and
// then a write.
// Write total_units only while busy is low.
module first_fit_allocator_unit #(
  parameter int MEM_UNITS    = ffa_pkg::MEM_UNITS_DEF,
  parameter int MAX_REQUESTS = ffa_pkg::MAX_REQUESTS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  ffa_pkg::req_t               req_i,
  output ffa_pkg::rsp_t               rsp_o,
  output logic                        rsp_valid_o,
  input  logic                        cfg_we_i,
  input  logic [ffa_pkg::FIELD_W-1:0] cfg_wdata_i
);

  ffa_pkg::cmd_t cmd;
  ffa_pkg::sts_t sts;

  // Sequence the clear after reset, then each request: check, scan, mark, commit
  ffa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  // Hold the occupancy map, grant records and request counter
  ffa_datapath #(
    .MEM_UNITS    (MEM_UNITS),
    .MAX_REQUESTS (MAX_REQUESTS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rsp_o       (rsp_o),
    .rsp_valid_o (rsp_valid_o)
  );

endmodule

@@ verif/tb_first_fit_allocator_unit.sv @@
`timescale 1ns / 1ps

module tb_first_fit_allocator_unit;

  localparam int CELLS = ffa_pkg::MEM_UNITS_DEF;
  localparam int SLOTS = ffa_pkg::MAX_REQUESTS_DEF;
  localparam int FW    = ffa_pkg::FIELD_W;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  ffa_pkg::req_t      req_i = '0;
  ffa_pkg::rsp_t      rsp_o;
  logic               rsp_valid_o;
  logic               cfg_we_i = 1'b0;
  logic [FW-1:0]      cfg_wdata_i = '0;

  first_fit_allocator_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .rsp_o      (rsp_o),
    .rsp_valid_o(rsp_valid_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("tb_first_fit_allocator_unit: errors");
    $finish;
  end

  // Shadow allocator state
  bit                 cell_busy [CELLS];
  bit                 grant_live[SLOTS];
  int                 grant_base[SLOTS];
  int                 grant_span[SLOTS];
  int                 numbered;
  logic [FW-1:0]      units_cfg = ffa_pkg::TOTAL_UNITS_RST;

  ffa_pkg::req_t pending_words[$];
  ffa_pkg::rsp_t expected_grants[$];
  int   error_count = 0;
  int   words_taken = 0;
  int   words_queued = 0;  // request numbers handed out by the stimulus side

  // Apply one accepted word to the shadow state; queue the answer of an allocate.
  function automatic void apply_word(ffa_pkg::req_t w);
    int   limit, run_base, run_len, want, r;
    bit   found, have_slot;
    ffa_pkg::rsp_t ans;
    have_slot = numbered < SLOTS;
    if (w.func == ffa_pkg::FUNC_ALLOC) begin
      want     = int'(w.size);
      limit    = (int'(units_cfg) < CELLS) ? int'(units_cfg) : CELLS;
      found    = 1'b0;
      run_len  = 0;
      run_base = 0;
      if (want != 0 && have_slot) begin
        for (int c = 0; c < limit && !found; c++) begin
          if (cell_busy[c]) begin
            run_len = 0;
          end else begin
            if (run_len == 0) run_base = c;
            run_len++;
            if (run_len >= want) found = 1'b1;
          end
        end
      end
      if (found) begin
        for (int c = run_base; c < run_base + want; c++) cell_busy[c] = 1'b1;
        grant_live[numbered] = 1'b1;
        grant_base[numbered] = run_base;
        grant_span[numbered] = want;
        ans.start_address = FW'(run_base + 1);
        ans.failed        = 1'b0;
      end else begin
        if (have_slot) grant_live[numbered] = 1'b0;
        ans.start_address = '0;
        ans.failed        = 1'b1;
      end
      expected_grants.insert(expected_grants.size(), ans);
    end else begin
      r = int'(w.ref_request);
      if (r >= 1 && r <= SLOTS && grant_live[r-1]) begin
        for (int c = grant_base[r-1]; c < grant_base[r-1] + grant_span[r-1] && c < CELLS; c++)
          cell_busy[c] = 1'b0;
        grant_live[r-1] = 1'b0;
      end
      if (have_slot) grant_live[numbered] = 1'b0;
    end
    if (have_slot) numbered++;
  endfunction

  // Driver: hold the word until taken, then advance or idle at random.
  // A long stretch of words runs with no idling at all.
  always @(posedge clk_i) begin
    bit taken, idle;
    taken = start && !busy;
    if (taken) begin
      apply_word(req_i);
      words_taken++;
    end
    idle = !(words_taken >= 250 && words_taken < 400) && ($urandom_range(99) < 37);
    if (start && !taken) begin
      // hold
    end else if (pending_words.size() > 0 && !idle && rst_ni) begin
      req_i <= pending_words.pop_front();
      start <= 1'b1;
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: results cannot be stalled, so check every strobe as it comes.
  always @(posedge clk_i) begin
    ffa_pkg::rsp_t exp_w;
    if (rst_ni && rsp_valid_o) begin
      if (expected_grants.size() == 0) begin
        $error("unexpected result word: start_address %0d failed %0b",
               rsp_o.start_address, rsp_o.failed);
        error_count++;
      end else begin
        exp_w = expected_grants.pop_front();
        if (rsp_o.start_address !== exp_w.start_address) begin
          $error("start_address: expected %0d, actual %0d",
                 exp_w.start_address, rsp_o.start_address);
          error_count++;
        end
        if (rsp_o.failed !== exp_w.failed) begin
          $error("failed: expected %0b, actual %0b", exp_w.failed, rsp_o.failed);
          error_count++;
        end
      end
    end
  end

  task automatic queue_alloc(int sz);
    ffa_pkg::req_t w;
    w.func        = ffa_pkg::FUNC_ALLOC;
    w.size        = FW'(sz);
    w.ref_request = FW'($urandom);
    pending_words.insert(pending_words.size(), w);
    words_queued++;
  endtask

  task automatic queue_free(int r);
    ffa_pkg::req_t w;
    w.func        = ffa_pkg::FUNC_FREE;
    w.size        = FW'($urandom);
    w.ref_request = FW'(r);
    pending_words.insert(pending_words.size(), w);
    words_queued++;
  endtask

  // Wait until every queued word is taken and every answer is checked.
  task automatic wait_drained();
    while (pending_words.size() != 0 || start || expected_grants.size() != 0)
      @(posedge clk_i);
  endtask

  // Drain everything, let the last free finish, then write the unit count.
  task automatic drain_then_set_units(int v);
    wait_drained();
    repeat (400) @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= FW'(v);
    units_cfg   = FW'(v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Mostly well-formed traffic: small allocates and frees of recent numbers.
  task automatic queue_random(int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 5) begin
        if ($urandom_range(1)) queue_alloc($urandom_range(2047));
        else queue_free($urandom_range(2047));
      end else if (k < 62) begin
        queue_alloc(($urandom_range(9) == 0) ? $urandom_range(1, 400) : $urandom_range(1, 24));
      end else if (words_queued > 0) begin
        queue_free($urandom_range((words_queued > 40) ? words_queued - 40 : 1, words_queued));
      end else begin
        queue_alloc(1);
      end
    end
  endtask

  initial begin
    int units_set[6];
    units_set = '{0, 1, 2047, 37, 300, 1024};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, double free, bad numbers, failed and free records
    queue_alloc(1);       // 1: grant at 1
    queue_alloc(1024);    // 2: fails, one cell used
    queue_alloc(0);       // 3: zero size fails
    queue_alloc(2047);    // 4: oversize fails
    queue_free(1);        // 5: live grant
    queue_free(1);        // 6: double free ignored
    queue_free(0);        // 7
    queue_free(2047);     // 8
    queue_free(1025);     // 9: one beyond the record count
    queue_free(3);        // 10: failed record
    queue_free(5);        // 11: a free's record
    queue_free(60);       // 12: not yet made
    queue_alloc(1024);    // 13: whole memory
    queue_alloc(1);       // 14: full, fails
    queue_free(13);
    queue_alloc(10);      // 16: grant at 1
    queue_alloc(5);       // 17: grant at 11
    queue_alloc(1000);    // 18: grant at 16
    queue_free(17);
    queue_alloc(6);       // 20: hole too small, grant at 1016
    queue_free(16);
    queue_alloc(15);      // 22: merged hole fits
    drain_then_set_units(12);
    queue_alloc(1);       // cells beyond the new limit stay live
    queue_free(18);
    queue_alloc(1);
    drain_then_set_units(1024);
    queue_free(22);

    foreach (units_set[p]) begin
      drain_then_set_units(units_set[p]);
      queue_random(88);
    end

    wait_drained();
    repeat (500) @(posedge clk_i);
    if (error_count == 0 && expected_grants.size() == 0) begin
      $display("tb_first_fit_allocator_unit: clean");
    end else begin
      $display("tb_first_fit_allocator_unit: errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/ffa_pkg.sv
sv/ffa_ctrl.sv
sv/ffa_datapath.sv
sv/first_fit_allocator_unit.sv
verif/tb_first_fit_allocator_unit.sv
